FILE: hdl/wma_pkg.sv
// wma_pkg: widths, depth and handshake types for the windowed moving average unit
// no dependencies; imported by every module of the block but wma_ram
`default_nettype none

package wma_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SAMPLE_W   = 16;
    localparam int WIN_W      = 5;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = SAMPLE_W + PTR_W;
    localparam int MAG_W      = SUM_W + FRAC_W;
    localparam int OUT_W      = 24;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam int IN_BYTES_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic               start;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
        logic [WIN_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [OUT_W-1:0]  quotient;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: hdl/wma_ram.sv
// wma_ram: generic single-write, single-read RAM with registered read data
// no dependencies; holds the sample ring of the moving average unit
`default_nettype none

module wma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wma_div.sv
// wma_div: radix-2 restoring divider, one quotient bit per cycle, sign applied at the end
// depends on wma_pkg for widths and the request and status structs
`default_nettype none

module wma_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wma_pkg::div_req_t  req,
    output wma_pkg::div_stat_t      stat
);

    import wma_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  q_reg, q_next;
    logic [WIN_W-1:0]  divisor_reg, divisor_next;
    logic              neg_reg, neg_next;

    logic [WIN_W:0]    shifted;
    logic [WIN_W:0]    diff;
    logic              fits;
    logic [MAG_W-1:0]  signed_q;

    assign shifted = {rem_reg, q_reg[MAG_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = (shifted >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = '0;
            q_next       = req.magnitude;
            divisor_next = req.divisor;
            neg_next     = req.negative;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits suffice
            rem_next = fits ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
            q_next   = {q_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign signed_q      = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = signed_q[OUT_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/windowed_moving_average_unit.sv
// windowed_moving_average_unit: top level, sequencer, running sum and output register
// depends on wma_pkg, wma_ram and wma_div
`default_nettype none

// Moving average of the last window_size signed 16-bit samples, returned as the mean times
// 256 truncated toward zero (24-bit signed, 8 fraction bits) with a window-full flag in
// m_tuser. During warm-up the mean is taken over the samples seen so far. One sample is
// worked on at a time: a sum update, a divider set-up, 28 radix-2 divider steps, a wait to
// see the divider finish and the output load lie between the input transfer and a valid
// result, and s_tready returns high the cycle after the result is loaded unless cfg_valid
// is high, so a new sample is taken only once the last result is in the output register.
// A write on the configuration channel sets window_size (0 reads as 1, values above 16 as
// 16) and restarts the window; it is taken only while no sample is in progress.

module windowed_moving_average_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [wma_pkg::IN_BYTES_W-1:0]     s_tdata,   // [15:0] sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [wma_pkg::OUT_BYTES_W-1:0]    m_tdata,   // [23:0] average_q8
    output logic      [0:0]                         m_tuser,   // [0] window_full
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wma_pkg::WIN_W-1:0]          cfg_data
);

    import wma_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [WIN_W-1:0]          wsz_reg, wsz_next;
    logic [PTR_W-1:0]          ptr_reg, ptr_next;
    logic [WIN_W-1:0]          fill_reg, fill_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic                      full_reg, full_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   avg_reg, avg_next;
    logic                      out_full_reg, out_full_next;

    logic                      in_xfer;
    logic                      cfg_xfer;
    logic                      out_load;
    logic [WIN_W-1:0]          cfg_sat;
    logic [WIN_W-1:0]          ptr_inc;
    logic                      is_full;
    logic [SAMPLE_W-1:0]       old_sample;
    logic [SUM_W-1:0]          old_ext;
    logic [SUM_W-1:0]          new_ext;
    logic [MAG_W-1:0]          scaled;
    div_req_t                  div_req;
    div_stat_t                 div_stat;

    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_sat = WIN_W'(1);
        end
        else if (cfg_data > WIN_W'(RING_DEPTH))
        begin
            cfg_sat = WIN_W'(RING_DEPTH);
        end
        else
        begin
            cfg_sat = cfg_data;
        end
    end

    assign is_full = (fill_reg >= wsz_reg);
    assign ptr_inc = WIN_W'(ptr_reg) + 1'b1;
    assign old_ext = {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
    assign new_ext = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign scaled  = {sum_reg, {FRAC_W{1'b0}}};

    wma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == ST_READ),
        .waddr (ptr_reg),
        .wdata (sample_reg),
        .re    (in_xfer),
        .raddr (ptr_reg),
        .rdata (old_sample)
    );

    always_comb
    begin
        div_req.start     = (state_reg == ST_START);
        div_req.negative  = sum_reg[SUM_W-1];
        div_req.magnitude = sum_reg[SUM_W-1] ? (~scaled + 1'b1) : scaled;
        div_req.divisor   = fill_reg;
    end

    wma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        wsz_next       = wsz_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        sample_next    = sample_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        out_full_next  = out_full_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_xfer)
                begin
                    wsz_next  = cfg_sat;
                    ptr_next  = '0;
                    fill_next = '0;
                    sum_next  = '0;
                end
                else if (in_xfer)
                begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // oldest sample leaves the window once it is full
                if (is_full)
                begin
                    sum_next  = sum_reg - signed'(old_ext) + signed'(new_ext);
                    fill_next = wsz_reg;
                    full_next = 1'b1;
                end
                else
                begin
                    sum_next  = sum_reg + signed'(new_ext);
                    fill_next = fill_reg + 1'b1;
                    full_next = ((fill_reg + 1'b1) == wsz_reg);
                end
                ptr_next   = (ptr_inc >= wsz_reg) ? '0 : ptr_inc[PTR_W-1:0];
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    avg_next       = div_stat.quotient;
                    out_full_next  = full_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wsz_reg       <= WIN_W'(RING_DEPTH);
            ptr_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wsz_reg       <= wsz_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        full_reg     <= full_next;
        avg_reg      <= avg_next;
        out_full_reg <= out_full_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BYTES_W'(unsigned'(avg_reg));
    assign m_tuser  = out_full_reg;

endmodule

`default_nettype wire

FILE: hdl/wma_checker.sv
// wma_checker: port-level assertions for the windowed moving average unit
// depends on wma_pkg for port widths; bound to windowed_moving_average_unit below
`default_nettype none

module wma_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [wma_pkg::IN_BYTES_W-1:0]     s_tdata,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [wma_pkg::OUT_BYTES_W-1:0]    m_tdata,
    input  wire logic [0:0]                         m_tuser,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [wma_pkg::WIN_W-1:0]          cfg_data
);

    import wma_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one sample at a time: input stays closed through the sum update, the divider set-up and the first divider step
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input reopened during a sample");

    // a new result is only loaded from the busy sequencer
    a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a sample in progress");

    // config channel closed during the sum update that follows a sample transfer
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !cfg_ready)
        else $error("config taken during a sample");

endmodule

bind windowed_moving_average_unit wma_checker u_wma_checker (.*);

`default_nettype wire

FILE: test/tb_windowed_moving_average_unit.sv
// tb_windowed_moving_average_unit: self-checking testbench for the windowed moving average unit
// drives samples and window-size writes, predicts each mean and flag, and checks every result
// depends on wma_pkg and windowed_moving_average_unit
`default_nettype none

module tb_windowed_moving_average_unit;

    import wma_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] average_q8;
        logic                    window_full;
    } mean_result_t;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_EXTREME,
        STYLE_SMALL,
        STYLE_HIGH,
        STYLE_LOW
    } sample_style_t;

    localparam int MAX_WINDOW  = RING_DEPTH;
    localparam int SETTLE_CYC  = 48;
    localparam int LONG_HOLD   = 300;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_BYTES_W-1:0]     s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_BYTES_W-1:0]    m_tdata;
    logic [0:0]                m_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [WIN_W-1:0]          cfg_data;

    // predictor state
    logic signed [SAMPLE_W-1:0] window_ring [MAX_WINDOW];
    logic [PTR_W-1:0]           write_ptr;
    logic [WIN_W-1:0]           fill_count;
    logic [WIN_W-1:0]           window_size;
    logic signed [SUM_W-1:0]    running_sum;

    mean_result_t mean_expect_q [$];

    int  fail_count      = 0;
    int  samples_sent    = 0;
    int  results_checked = 0;
    int  window_writes   = 0;
    int  hold_off_cycles = 0;
    bit  src_idle_en     = 1'b1;
    bit  sink_idle_en    = 1'b1;

    windowed_moving_average_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void restart_window();
        write_ptr   = '0;
        fill_count  = '0;
        running_sum = '0;
    endfunction

    function automatic void set_window_size(input logic [WIN_W-1:0] value);
        if (value == 0)
            window_size = WIN_W'(1);
        else if (value > MAX_WINDOW)
            window_size = WIN_W'(MAX_WINDOW);
        else
            window_size = value;
        restart_window();
    endfunction

    function automatic mean_result_t predict_mean(input logic signed [SAMPLE_W-1:0] value);
        mean_result_t res;
        longint       scaled;
        if (fill_count >= window_size)
            running_sum = running_sum - window_ring[write_ptr];
        else
            fill_count = fill_count + 1'b1;
        window_ring[write_ptr] = value;
        running_sum = running_sum + value;
        if (WIN_W'(write_ptr) + WIN_W'(1) >= window_size)
            write_ptr = '0;
        else
            write_ptr = write_ptr + 1'b1;
        scaled = longint'(running_sum) * 256;
        res.average_q8  = OUT_W'(scaled / longint'(fill_count));
        res.window_full = (fill_count == window_size);
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_style_t style);
        case (style)
            STYLE_EXTREME: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            STYLE_SMALL:   return 16'($urandom_range(0, 600)) - 16'd300;
            STYLE_HIGH:    return 16'h7FFF - 16'($urandom_range(0, 15));
            STYLE_LOW:     return 16'h8000 + 16'($urandom_range(0, 15));
            default:       return 16'($urandom());
        endcase
    endfunction

    function automatic sample_style_t pick_style();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return STYLE_RANDOM;
        else if (roll < 6)
            return STYLE_EXTREME;
        else if (roll < 8)
            return STYLE_SMALL;
        else if (roll < 9)
            return STYLE_HIGH;
        else
            return STYLE_LOW;
    endfunction

    // one sample transfer; s_tvalid stays high for the caller's next sample
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mean_expect_q.push_back(predict_mean(value));
        samples_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mean_expect_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_window_size(input logic [WIN_W-1:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        set_window_size(value);
        window_writes++;
    endtask

    task automatic send_run(input int count, input sample_style_t style);
        repeat (count) send_sample(pick_sample(style));
    endtask

    // warm-up at reset size, saturating writes, truncation toward zero and ring wrap
    task automatic test_directed_extremes();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd0);
        write_window_size(5'd0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(-16'sd1);
        write_window_size(5'd3);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(16'sd5);
        write_window_size(5'd2);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        write_window_size(5'd31);
        send_sample(16'sh5A5A);
        write_window_size(5'd17);
        send_sample(16'shA5A5);
        write_window_size(5'd16);
        send_sample(16'sh0001);
    endtask

    task automatic test_random_windows();
        int            phase;
        int            roll;
        logic [WIN_W-1:0] size;
        for (phase = 0; phase < 40; phase++)
        begin
            roll = $urandom_range(0, 5);
            case (roll)
                0:       size = WIN_W'(1);
                1:       size = WIN_W'(MAX_WINDOW);
                2:       size = WIN_W'($urandom_range(0, 31));
                default: size = WIN_W'($urandom_range(1, MAX_WINDOW));
            endcase
            // some phases keep the previous size and so only carry on the window
            if ($urandom_range(0, 4) != 0)
                write_window_size(size);
            send_run($urandom_range(10, 60), pick_style());
        end
    endtask

    // output held off long enough to back up the input, then a pause until all is drained
    task automatic test_output_backpressure();
        bit saved_idle;
        saved_idle  = src_idle_en;
        src_idle_en = 1'b0;
        write_window_size(WIN_W'(MAX_WINDOW));
        hold_off_cycles = LONG_HOLD;
        send_run(12, STYLE_HIGH);
        src_idle_en = saved_idle;
        wait_results_drained();
        send_run(8, STYLE_RANDOM);
    endtask

    task automatic test_back_to_back();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_window_size(WIN_W'($urandom_range(1, MAX_WINDOW)));
        send_run(150, STYLE_RANDOM);
        write_window_size(WIN_W'(MAX_WINDOW));
        send_run(200, pick_style());
    endtask

    initial
    begin : result_sink
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                m_tready <= 1'b1;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        mean_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mean_expect_q.size() == 0)
            begin
                $error("unexpected result: average_q8 %0d window_full %0d",
                       $signed(m_tdata[OUT_W-1:0]), m_tuser[0]);
                fail_count++;
            end
            else
            begin
                want = mean_expect_q.pop_front();
                results_checked++;
                if (m_tdata[OUT_W-1:0] !== want.average_q8)
                begin
                    $error("average_q8 mismatch: expected %0d, actual %0d",
                           want.average_q8, $signed(m_tdata[OUT_W-1:0]));
                    fail_count++;
                end
                if (m_tuser[0] !== want.window_full)
                begin
                    $error("window_full mismatch: expected %0d, actual %0d",
                           want.window_full, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        set_window_size(WIN_W'(MAX_WINDOW));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_random_windows();
        test_output_backpressure();
        test_back_to_back();
        wait_results_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        if (mean_expect_q.size() != 0)
        begin
            $error("%0d results never arrived", mean_expect_q.size());
            fail_count++;
        end
        $display("run covered %0d samples and %0d checked results over %0d window-size writes,",
                 samples_sent, results_checked, window_writes);
        $display("including saturating writes, output hold-off and back-to-back transfers");
        if (fail_count == 0)
            $display("windowed_moving_average_unit verification clean");
        else
            $display("windowed_moving_average_unit verification failed");
        $finish;
    end

    initial
    begin
        #(8 * 3000000);
        $display("windowed_moving_average_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
